[rtl/core/fbct_pkg.sv]
// shared types and constants of the frustum box cull test
package fbct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NEAR_IDX   = 4;
    localparam int FAR_IDX    = 5;

    localparam int COORD_W    = 16;
    localparam int PROD_W     = 32;
    localparam int XF_W       = 33;
    localparam int TERM_W     = 49;
    localparam int SUM_W      = 51;
    localparam int OFF_SHIFT  = 8;
    localparam int D_SHIFT    = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int VEC3_W     = 48;
    localparam int PLANE_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(7);

    localparam logic [VEC3_W-1:0] SCALE_RESET = 48'h0100_0100_0100;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [XF_W-1:0]    t_xf;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_vec3;

    typedef struct packed {
        t_coord d;
        t_coord c;
        t_coord b;
        t_coord a;
    } t_plane;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

[rtl/core/fbct_xform.sv]
// model transform of both box corners: multiply stage then offset stage
module fbct_xform (
    input  logic              i_clk,
    input  fbct_pkg::t_pipe_en i_en,
    input  fbct_pkg::t_vec3   i_scale,
    input  fbct_pkg::t_vec3   i_offset,
    input  fbct_pkg::t_vec3   i_lo,
    input  fbct_pkg::t_vec3   i_hi,
    output fbct_pkg::t_xf     o_t_lo [fbct_pkg::NUM_AXES],
    output fbct_pkg::t_xf     o_t_hi [fbct_pkg::NUM_AXES]
);
    import fbct_pkg::*;

    t_coord scale_a [NUM_AXES];
    t_coord off_a   [NUM_AXES];
    t_coord lo_a    [NUM_AXES];
    t_coord hi_a    [NUM_AXES];

    t_prod r_p_lo [NUM_AXES];
    t_prod r_p_hi [NUM_AXES];
    t_xf   r_t_lo [NUM_AXES];
    t_xf   r_t_hi [NUM_AXES];

    assign scale_a = '{i_scale.x, i_scale.y, i_scale.z};
    assign off_a   = '{i_offset.x, i_offset.y, i_offset.z};
    assign lo_a    = '{i_lo.x, i_lo.y, i_lo.z};
    assign hi_a    = '{i_hi.x, i_hi.y, i_hi.z};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (i_en.s1) begin
                r_p_lo[k] <= PROD_W'(scale_a[k]) * PROD_W'(lo_a[k]);
                r_p_hi[k] <= PROD_W'(scale_a[k]) * PROD_W'(hi_a[k]);
            end
            if (i_en.s2) begin
                r_t_lo[k] <= XF_W'(r_p_lo[k]) + (XF_W'(off_a[k]) <<< OFF_SHIFT);
                r_t_hi[k] <= XF_W'(r_p_hi[k]) + (XF_W'(off_a[k]) <<< OFF_SHIFT);
            end
        end
    end

    assign o_t_lo = r_t_lo;
    assign o_t_hi = r_t_hi;

endmodule

[rtl/core/fbct_plane.sv]
// one clip plane: p-vertex select and products, then signed sum and sign test
module fbct_plane (
    input  logic               i_clk,
    input  fbct_pkg::t_pipe_en i_en,
    input  fbct_pkg::t_plane   i_plane,
    input  fbct_pkg::t_xf      i_t_lo [fbct_pkg::NUM_AXES],
    input  fbct_pkg::t_xf      i_t_hi [fbct_pkg::NUM_AXES],
    output logic               o_neg
);
    import fbct_pkg::*;

    t_coord coef_a [NUM_AXES];
    t_xf    sel    [NUM_AXES];
    t_sum   sum;

    t_term r_m [NUM_AXES];
    logic  r_neg;

    assign coef_a = '{i_plane.a, i_plane.b, i_plane.c};

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            sel[k] = coef_a[k][COORD_W-1] ? i_t_lo[k] : i_t_hi[k];
        end
        sum = SUM_W'(r_m[0]) + SUM_W'(r_m[1]) + SUM_W'(r_m[2])
            + (SUM_W'(i_plane.d) <<< D_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_m[k] <= TERM_W'(coef_a[k]) * TERM_W'(sel[k]);
            end
        end
        if (i_en.s4) begin
            r_neg <= sum[SUM_W-1];
        end
    end

    assign o_neg = r_neg;

endmodule

[rtl/core/frustum_box_cull_test.sv]
// frustum box cull test: top level with config registers and pipeline control
// 5 register stages lie between the input transfer and the result
// one box per cycle while the result side does not stall; stages are transform multiply, offset add,
// plane products, plane sums and the final cull decision
// bubbles are squeezed out while the result side stalls
// synchronous active-low reset empties the pipeline and loads register defaults
module frustum_box_cull_test (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fbct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fbct_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [fbct_pkg::COORD_W-1:0] i_min_x,
    input  logic signed [fbct_pkg::COORD_W-1:0] i_min_y,
    input  logic signed [fbct_pkg::COORD_W-1:0] i_min_z,
    input  logic signed [fbct_pkg::COORD_W-1:0] i_max_x,
    input  logic signed [fbct_pkg::COORD_W-1:0] i_max_y,
    input  logic signed [fbct_pkg::COORD_W-1:0] i_max_z,
    input  logic                              i_depth_clamp,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_culled
);
    import fbct_pkg::*;

    t_plane r_plane [NUM_PLANES];
    t_vec3  r_scale;
    t_vec3  r_offset;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_clamp1, r_clamp2, r_clamp3, r_clamp4;
    logic r_culled;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    t_pipe_en en;
    t_vec3    box_lo;
    t_vec3    box_hi;
    t_xf      t_lo [NUM_AXES];
    t_xf      t_hi [NUM_AXES];
    logic [NUM_PLANES-1:0] neg;
    logic [NUM_PLANES-1:0] tested;
    logic     n_culled;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
            r_scale  <= SCALE_RESET;
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx < CFG_IDX_W'(NUM_PLANES)) begin
                r_plane[i_cfg_idx[PLANE_IDX_W-1:0]] <= i_cfg_wr_data;
            end else if (i_cfg_idx == REG_SCALE) begin
                r_scale <= i_cfg_wr_data[VEC3_W-1:0];
            end else if (i_cfg_idx == REG_OFFSET) begin
                r_offset <= i_cfg_wr_data[VEC3_W-1:0];
            end
        end
    end

    // per-stage flow control
    assign rdy5 = !r_v5 || !i_out_stall;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_clamp1 <= i_depth_clamp;
        if (rdy2) r_clamp2 <= r_clamp1;
        if (rdy3) r_clamp3 <= r_clamp2;
        if (rdy4) r_clamp4 <= r_clamp3;
        if (rdy5) r_culled <= n_culled;
    end

    assign box_lo = '{z: i_min_z, y: i_min_y, x: i_min_x};
    assign box_hi = '{z: i_max_z, y: i_max_y, x: i_max_x};

    fbct_xform u_xform (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_scale  (r_scale),
        .i_offset (r_offset),
        .i_lo     (box_lo),
        .i_hi     (box_hi),
        .o_t_lo   (t_lo),
        .o_t_hi   (t_hi)
    );

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fbct_plane u_plane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_plane (r_plane[p]),
            .i_t_lo  (t_lo),
            .i_t_hi  (t_hi),
            .o_neg   (neg[p])
        );
    end

    // near and far planes drop out under depth clamp
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            tested[p] = !(r_clamp4 && (p == NEAR_IDX || p == FAR_IDX));
        end
        n_culled = |(neg & tested);
    end

    assign o_out_valid = r_v5;
    assign o_culled    = r_culled;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted transfer not held in first stage");

    a_stage_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && rdy5) |=> r_v5)
        else $error("result lost between last two stages");

    a_no_drop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy4) |=> (r_v3 && r_v4))
        else $error("stalled stage dropped its item");
`endif

endmodule
